// ===== hdl/xtl_pkg.sv =====
// Shared types and constants for the XYZ to CIELAB pixel pipeline.
package xtl_pkg;

  localparam int LANES       = 3;
  localparam int COMP_W      = 16;
  localparam int RATIO_W     = 40;
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 22;
  localparam int LIN_W       = 18;
  localparam int DIV_STAGES  = RATIO_W / 2;
  localparam int CBRT_STAGES = ROOT_W;

  // Cube branch when the Q.24 ratio is above this
  localparam logic [RATIO_W-1:0] THRESH_Q24 = 40'd148579;
  // 16/116 in Q.16
  localparam int OFFSET_Q16 = 9039;
  // Linear segment: 7787 / 256000, and 256000 = 2^11 * 125
  localparam int LIN_MUL    = 7787;
  localparam int RECIP125   = 1073741;
  // Linear lightness: (9033*t + 327680) / 655360, and 655360 = 2^17 * 5
  localparam int L_MUL      = 9033;
  localparam int L_BIAS     = 327680;
  localparam int RECIP5     = 52429;

  typedef enum logic [1:0] {
    REG_WHITE_X = 2'd0,
    REG_WHITE_Y = 2'd1,
    REG_WHITE_Z = 2'd2
  } reg_idx_t;

  // Side data that rides along with each lane through the cube root
  typedef struct packed {
    logic             cube;
    logic [LIN_W-1:0] lin_t;
  } side_t;

endpackage

// ===== hdl/xtl_divide.sv =====
// Pipelined restoring divider: ratio = (comp << 24) / white, two bits per stage, three lanes.
module xtl_divide (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  logic [xtl_pkg::LANES-1:0][xtl_pkg::COMP_W-1:0]  comp,
  input  logic [xtl_pkg::LANES-1:0][xtl_pkg::COMP_W-1:0]  white,
  output logic                                        out_valid,
  output logic [xtl_pkg::LANES-1:0][xtl_pkg::RATIO_W-1:0] ratio
);
  import xtl_pkg::*;

  logic                vld [DIV_STAGES+1];
  logic [COMP_W-1:0]   rem [DIV_STAGES+1][LANES];
  logic [COMP_W-1:0]   num [DIV_STAGES+1][LANES];
  logic [RATIO_W-1:0]  quo [DIV_STAGES+1][LANES];

  // One restoring step: shift in a bit, subtract when it fits
  function automatic logic [COMP_W:0] div_step(input logic [COMP_W-1:0] r, input logic b,
                                               input logic [COMP_W-1:0] w);
    logic [COMP_W:0] t;
    t = {r, b};
    if (t >= {1'b0, w}) begin
      div_step = {1'b1, COMP_W'(t - {1'b0, w})};
    end else begin
      div_step = {1'b0, t[COMP_W-1:0]};
    end
  endfunction

  // Feed stage zero
  assign vld[0] = in_valid;
  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign rem[0][l] = '0;
    assign num[0][l] = comp[l];
    assign quo[0][l] = '0;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [COMP_W:0] s0;
      logic [COMP_W:0] s1;

      // Two dependent 17-bit steps
      always_comb begin
        s0 = div_step(rem[k][l], num[k][l][COMP_W-1], white[l]);
        s1 = div_step(s0[COMP_W-1:0], num[k][l][COMP_W-2], white[l]);
      end

      // Advance remainder, dividend bits and quotient
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1][l] <= s1[COMP_W-1:0];
          num[k+1][l] <= {num[k][l][COMP_W-3:0], 2'b00};
          quo[k+1][l] <= {quo[k][l][RATIO_W-3:0], s0[COMP_W], s1[COMP_W]};
        end
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign ratio[l] = quo[DIV_STAGES][l];
  end

endmodule

// ===== hdl/xtl_cbrt.sv =====
// Pipelined digit-by-digit integer cube root of (ratio << 24), one result bit per stage.
module xtl_cbrt (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [xtl_pkg::LANES-1:0][xtl_pkg::RATIO_W-1:0]  ratio,
  output logic                                         out_valid,
  output logic [xtl_pkg::LANES-1:0][xtl_pkg::ROOT_W-1:0]   root,
  output xtl_pkg::side_t [xtl_pkg::LANES-1:0]          side
);
  import xtl_pkg::*;

  localparam int SQ_W = 2 * ROOT_W;
  localparam int B_W  = SQ_W + 3;

  logic               vld [CBRT_STAGES+1];
  logic [RAD_W-1:0]   rad [CBRT_STAGES+1][LANES];
  logic [ROOT_W-1:0]  yv  [CBRT_STAGES+1][LANES];
  logic [SQ_W-1:0]    y2  [CBRT_STAGES+1][LANES];
  side_t              sd  [CBRT_STAGES+1][LANES];

  // Load radicand and classify each lane
  assign vld[0] = in_valid;
  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign rad[0][l]      = {ratio[l], 24'd0};
    assign yv[0][l]       = '0;
    assign y2[0][l]       = '0;
    assign sd[0][l].cube  = (ratio[l] > THRESH_Q24);
    assign sd[0][l].lin_t = ratio[l][LIN_W-1:0];
  end

  for (genvar i = 0; i < CBRT_STAGES; i++) begin : g_stage
    localparam int SH = RAD_W - 1 - 3 * i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ROOT_W-1:0] yd;
      logic [SQ_W-1:0]   y2d;
      logic [B_W-1:0]    bv;
      logic              take;

      // Trial: b = 3*(y^2 + y) + 1 with y doubled
      always_comb begin
        yd   = {yv[i][l][ROOT_W-2:0], 1'b0};
        y2d  = {y2[i][l][SQ_W-3:0], 2'b00};
        bv   = B_W'(3) * (B_W'(y2d) + B_W'(yd)) + B_W'(1);
        take = ((rad[i][l] >> SH) >= RAD_W'(bv));
      end

      // Advance partial root and remainder
      always_ff @(posedge clk) begin
        if (en) begin
          sd[i+1][l] <= sd[i][l];
          if (take) begin
            rad[i+1][l] <= rad[i][l] - (RAD_W'(bv) << SH);
            yv[i+1][l]  <= yd | ROOT_W'(1);
            y2[i+1][l]  <= y2d + SQ_W'({yd, 1'b0}) + SQ_W'(1);
          end else begin
            rad[i+1][l] <= rad[i][l];
            yv[i+1][l]  <= yd;
            y2[i+1][l]  <= y2d;
          end
        end
      end
    end
  end

  assign out_valid = vld[CBRT_STAGES];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign root[l] = yv[CBRT_STAGES][l];
    assign side[l] = sd[CBRT_STAGES][l];
  end

endmodule

// ===== hdl/xtl_lab.sv =====
// Linear segment, L/a/b arithmetic, saturation and output register.
module xtl_lab (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  logic [xtl_pkg::LANES-1:0][xtl_pkg::ROOT_W-1:0]  root,
  input  xtl_pkg::side_t [xtl_pkg::LANES-1:0]         side,
  output logic                                        out_valid,
  output logic [15:0]                                 lightness,
  output logic signed [15:0]                          red_green,
  output logic signed [15:0]                          yellow_blue,
  output logic                                        clipped
);
  import xtl_pkg::*;

  // Stage 1: linear products
  logic               v1;
  logic [30:0]        p1    [LANES];
  logic [31:0]        ln1;
  logic [ROOT_W-1:0]  root1 [LANES];
  logic               cube1 [LANES];

  // Stage 2: reciprocal multiplies
  logic               v2;
  logic [19:0]        u2    [LANES];
  logic [13:0]        q02   [LANES];
  logic [12:0]        lq2;
  logic [ROOT_W-1:0]  root2 [LANES];
  logic               cube2 [LANES];

  // Stage 3: companded values
  logic               v3;
  logic [ROOT_W-1:0]  f3    [LANES];
  logic [12:0]        lq3;
  logic               cy3;

  // Stage 4: scaled differences
  logic               v4;
  logic [30:0]        na4;
  logic [30:0]        nb4;
  logic [28:0]        lc4;
  logic [12:0]        lq4;
  logic               cy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        p1[l]    <= 31'(LIN_MUL) * 31'(side[l].lin_t);
        root1[l] <= root[l];
        cube1[l] <= side[l].cube;
      end
      ln1 <= 32'(L_MUL) * 32'(side[1].lin_t) + 32'(L_BIAS);
    end
  end

  // Stage 2
  logic [40:0] qp [LANES];
  logic [30:0] lp;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qp[l] = 41'(p1[l][30:11]) * 41'(RECIP125);
    end
    lp = 31'(ln1[31:17]) * 31'(RECIP5);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        u2[l]    <= p1[l][30:11];
        q02[l]   <= qp[l][40:27];
        root2[l] <= root1[l];
        cube2[l] <= cube1[l];
      end
      lq2 <= lp[30:18];
    end
  end

  // Stage 3: correct quotient by 125, pick branch
  logic [20:0]       rm   [LANES];
  logic [13:0]       qc   [LANES];
  logic [ROOT_W-1:0] flin [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rm[l]   = 21'(u2[l]) - 21'(q02[l]) * 21'(125);
      qc[l]   = q02[l] + ((rm[l] >= 21'(125)) ? 14'd1 : 14'd0);
      flin[l] = ROOT_W'(qc[l]) + ROOT_W'(OFFSET_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        f3[l] <= cube2[l] ? root2[l] : flin[l];
      end
      lq3 <= lq2;
      cy3 <= cube2[1];
    end
  end

  // Stage 4
  logic [30:0] da;
  logic [30:0] db;
  always_comb begin
    da = 31'(f3[0]) - 31'(f3[1]);
    db = 31'(f3[1]) - 31'(f3[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na4 <= da * 31'(125) + 31'(256);
      nb4 <= db * 31'(25) + 31'(128);
      lc4 <= 29'(f3[1]) * 29'(116) + 29'(128);
      lq4 <= lq3;
      cy4 <= cy3;
    end
  end

  // Stage 5: shift, saturate, hold for the consumer
  logic signed [30:0] an;
  logic signed [30:0] bn;
  logic signed [21:0] lcs;
  logic [15:0]        l_o;
  logic [15:0]        a_o;
  logic [15:0]        b_o;
  logic               clip;
  always_comb begin
    an   = $signed(na4) >>> 9;
    bn   = $signed(nb4) >>> 8;
    lcs  = $signed({1'b0, lc4[28:8]}) - 22'sd4096;
    clip = 1'b0;
    if (cy4) begin
      if (lcs < 0) begin
        l_o  = 16'd0;
        clip = 1'b1;
      end else if (lcs > 22'sd65535) begin
        l_o  = 16'hFFFF;
        clip = 1'b1;
      end else begin
        l_o = lcs[15:0];
      end
    end else begin
      l_o = 16'(lq4);
    end
    if (an > 31'sd32767) begin
      a_o  = 16'h7FFF;
      clip = 1'b1;
    end else if (an < -31'sd32768) begin
      a_o  = 16'h8000;
      clip = 1'b1;
    end else begin
      a_o = an[15:0];
    end
    if (bn > 31'sd32767) begin
      b_o  = 16'h7FFF;
      clip = 1'b1;
    end else if (bn < -31'sd32768) begin
      b_o  = 16'h8000;
      clip = 1'b1;
    end else begin
      b_o = bn[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lightness   <= l_o;
      red_green   <= a_o;
      yellow_blue <= b_o;
      clipped     <= clip;
    end
  end

endmodule

// ===== hdl/xyz_to_lab_pixel_core.sv =====
// XYZ to CIELAB pixel converter.
// Throughput one pixel per cycle unless stalled: divider (20 stages), cube root (22), output math (5).
// The whole pipeline advances together; it holds while a result waits under stall.
// Synchronous reset clears all valid bits and loads the D65 white point registers.
// Configuration port is always ready.
module xyz_to_lab_pixel_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic [15:0]        comp_x,
  input  logic [15:0]        comp_y,
  input  logic [15:0]        comp_z,
  output logic               lab_valid,
  input  logic               lab_stall,
  output logic [15:0]        lightness,
  output logic signed [15:0] red_green,
  output logic signed [15:0] yellow_blue,
  output logic               clipped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import xtl_pkg::*;

  logic [COMP_W-1:0] white_x;
  logic [COMP_W-1:0] white_y;
  logic [COMP_W-1:0] white_z;
  logic              en;

  logic [LANES-1:0][COMP_W-1:0]  comp;
  logic [LANES-1:0][COMP_W-1:0]  wv;
  logic [LANES-1:0][RATIO_W-1:0] ratio;
  logic [LANES-1:0][ROOT_W-1:0]  root;
  side_t [LANES-1:0]             side;
  logic                          div_valid;
  logic                          cbrt_valid;

  // Advance unless a result waits under stall
  assign en          = !lab_valid || !lab_stall;
  assign pixel_stall = !en;
  assign cfg_ready   = 1'b1;

  // White point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      white_x <= 16'd31144;
      white_y <= 16'd32768;
      white_z <= 16'd35676;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WHITE_X: white_x <= cfg_data;
        REG_WHITE_Y: white_y <= cfg_data;
        REG_WHITE_Z: white_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero white component acts as one
  assign wv[0] = (white_x == '0) ? COMP_W'(1) : white_x;
  assign wv[1] = (white_y == '0) ? COMP_W'(1) : white_y;
  assign wv[2] = (white_z == '0) ? COMP_W'(1) : white_z;

  assign comp[0] = comp_x;
  assign comp[1] = comp_y;
  assign comp[2] = comp_z;

  xtl_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel_valid),
    .comp      (comp),
    .white     (wv),
    .out_valid (div_valid),
    .ratio     (ratio)
  );

  xtl_cbrt u_cbrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .ratio     (ratio),
    .out_valid (cbrt_valid),
    .root      (root),
    .side      (side)
  );

  xtl_lab u_lab (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (cbrt_valid),
    .root        (root),
    .side        (side),
    .out_valid   (lab_valid),
    .lightness   (lightness),
    .red_green   (red_green),
    .yellow_blue (yellow_blue),
    .clipped     (clipped)
  );

endmodule
